// ===== design/pfba_pkg.sv =====
// ----------------------------------------------------------------------------
// pfba_pkg
// Constants, opcodes and helpers shared by the page frame bitmap allocator.
// ----------------------------------------------------------------------------
package pfba_pkg;

  // Map geometry: one used bit per 4 KiB frame, 32 frames per word
  localparam int unsigned FRAME_SHIFT = 12;
  localparam int unsigned WORD_BITS   = 32;
  localparam int unsigned BIT_W       = 5;
  localparam int unsigned MAP_WORDS   = 32768;
  localparam int unsigned MAP_AW      = 15;
  localparam int unsigned ADDR_W      = 32;
  // Reserved frame count: ceil(addr / 4096) fits in 21 bits
  localparam int unsigned NFR_W       = ADDR_W - FRAME_SHIFT + 1;

  localparam logic [WORD_BITS-1:0] FULL_WORD = '1;
  localparam logic [ADDR_W:0]      FRAME_RND = (ADDR_W + 1)'(4095);

  // Opcodes
  localparam logic [1:0] OP_INIT  = 2'd0;
  localparam logic [1:0] OP_MARK  = 2'd1;
  localparam logic [1:0] OP_FREE  = 2'd2;
  localparam logic [1:0] OP_ALLOC = 2'd3;

  // Controller state codes
  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_SWEEP  = 3'd2;
  localparam logic [2:0] ST_MODIFY = 3'd3;
  localparam logic [2:0] ST_CHECK  = 3'd4;

  // Index of the lowest clear bit (word known not to be full)
  function automatic logic [BIT_W-1:0] lowest_zero(input logic [WORD_BITS-1:0] w);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!w[i]) begin
        idx = BIT_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ===== design/page_frame_bitmap_allocator.sv =====
// ----------------------------------------------------------------------------
// page_frame_bitmap_allocator
// First-fit physical page frame allocator over a 32768 x 32 bit used-map.
// ----------------------------------------------------------------------------
// The block keeps one used bit per 4 KiB frame in a single-port-style
// synchronous RAM (one read, one write per cycle, registered read data).
// Each input transaction carries an opcode in tuser (init, mark, free,
// allocate) and a frame byte address in tdata; each one produces exactly
// one output transaction. Mark and free read the word, then modify and
// write it back. Allocate scans one map word per cycle from word
// rsv_limit_q[31:17] upward past full words, then sets the lowest clear
// bit, or reports not found at the top of the map. Init rewrites every
// map word, one per cycle, the last one held while the output register
// is full. After reset the block runs a clearing pass over all 32768
// map words and holds s_axis_tready low meanwhile; cfg writes are taken
// at any time. A finished result sits in the output register while the
// next input transaction is accepted; the block only stalls its final
// step (write back, or a failed scan's result) while that register is
// still full.
// ----------------------------------------------------------------------------
module page_frame_bitmap_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: reserved end address
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] frame byte address
  input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [31:0] allocated_address, [63:32] word_after
  output logic        m_axis_tuser    // [0] found
);

  localparam int unsigned AW = pfba_pkg::MAP_AW;
  localparam int unsigned DW = pfba_pkg::WORD_BITS;
  localparam int unsigned BW = pfba_pkg::BIT_W;
  localparam int unsigned NW = pfba_pkg::NFR_W;

  // --------------------------------------------------------------------------
  // Used-map RAM
  // --------------------------------------------------------------------------
  logic [DW-1:0] map_mem [pfba_pkg::MAP_WORDS];
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [DW-1:0] rd_data_q;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [DW-1:0] wr_data;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      map_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= map_mem[rd_addr];
    end
  end

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  logic [31:0] rsv_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsv_limit_q <= '0;
    end else if (cfg_we_i) begin
      rsv_limit_q <= cfg_wdata_i;
    end
  end

  // --------------------------------------------------------------------------
  // Control
  // --------------------------------------------------------------------------
  logic [2:0]    state_q, state_d;
  logic [AW-1:0] cnt_q, cnt_d;       // sweep word index / scan word index
  logic [NW-1:0] nfr_q, nfr_d;       // reserved frame count for init
  logic          is_free_q, is_free_d;
  logic [BW-1:0] bit_q, bit_d;

  logic          out_valid_q, out_valid_d;
  logic [31:0]   out_addr_q, out_addr_d;
  logic          out_found_q, out_found_d;
  logic [DW-1:0] out_word_q, out_word_d;

  logic          in_acc;
  logic          out_free;
  logic          res_load;
  logic [31:0]   res_addr;
  logic          res_found;
  logic [DW-1:0] res_word;

  logic [pfba_pkg::ADDR_W:0] rnd_sum;
  logic [NW-1:0]             nfr_new;
  logic [NW-BW-1:0]          cnt_ext;
  logic [DW-1:0]             init_word;
  logic [DW-1:0]             mask;
  logic [BW-1:0]             free_bit;
  logic                      cnt_last;

  assign s_axis_tready = (state_q == pfba_pkg::ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign cnt_last      = (cnt_q == '1);

  // ceil(reserved end / 4096)
  assign rnd_sum = {1'b0, rsv_limit_q} + pfba_pkg::FRAME_RND;
  assign nfr_new = rnd_sum[pfba_pkg::ADDR_W:pfba_pkg::FRAME_SHIFT];

  // Init word for index cnt_q: full below the reserved count's word,
  // partial mask in that word, clear above.
  assign cnt_ext = {1'b0, cnt_q};
  always_comb begin
    if (nfr_q[NW-1:BW] > cnt_ext) begin
      init_word = pfba_pkg::FULL_WORD;
    end else if (nfr_q[NW-1:BW] == cnt_ext) begin
      init_word = (DW'(1) << nfr_q[BW-1:0]) - DW'(1);
    end else begin
      init_word = '0;
    end
  end

  assign mask     = DW'(1) << bit_q;
  assign free_bit = pfba_pkg::lowest_zero(rd_data_q);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    nfr_d     = nfr_q;
    is_free_d = is_free_q;
    bit_d     = bit_q;
    rd_en     = 1'b0;
    rd_addr   = cnt_q;
    wr_en     = 1'b0;
    wr_addr   = cnt_q;
    wr_data   = '0;
    res_load  = 1'b0;
    res_addr  = '0;
    res_found = 1'b0;
    res_word  = '0;

    case (state_q)
      pfba_pkg::ST_CLEAR: begin
        // post-reset pass: every frame free
        wr_en = 1'b1;
        cnt_d = cnt_q + AW'(1);
        if (cnt_last) begin
          state_d = pfba_pkg::ST_IDLE;
        end
      end

      pfba_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (s_axis_tuser)
            pfba_pkg::OP_INIT: begin
              nfr_d   = nfr_new;
              cnt_d   = '0;
              state_d = pfba_pkg::ST_SWEEP;
            end
            pfba_pkg::OP_MARK, pfba_pkg::OP_FREE: begin
              rd_en     = 1'b1;
              rd_addr   = s_axis_tdata[pfba_pkg::FRAME_SHIFT+BW +: AW];
              cnt_d     = s_axis_tdata[pfba_pkg::FRAME_SHIFT+BW +: AW];
              bit_d     = s_axis_tdata[pfba_pkg::FRAME_SHIFT +: BW];
              is_free_d = (s_axis_tuser == pfba_pkg::OP_FREE);
              state_d   = pfba_pkg::ST_MODIFY;
            end
            default: begin
              // allocate: scan from the word holding the reserved end
              rd_en   = 1'b1;
              rd_addr = rsv_limit_q[pfba_pkg::FRAME_SHIFT+BW +: AW];
              cnt_d   = rsv_limit_q[pfba_pkg::FRAME_SHIFT+BW +: AW];
              state_d = pfba_pkg::ST_CHECK;
            end
          endcase
        end
      end

      pfba_pkg::ST_SWEEP: begin
        // last word waits for the output register so the result goes with it
        if (!cnt_last || out_free) begin
          wr_en   = 1'b1;
          wr_data = init_word;
          cnt_d   = cnt_q + AW'(1);
          if (cnt_last) begin
            res_load = 1'b1;
            state_d  = pfba_pkg::ST_IDLE;
          end
        end
      end

      pfba_pkg::ST_MODIFY: begin
        if (out_free) begin
          wr_en    = 1'b1;
          wr_data  = is_free_q ? (rd_data_q & ~mask) : (rd_data_q | mask);
          res_load = 1'b1;
          res_word = wr_data;
          state_d  = pfba_pkg::ST_IDLE;
        end
      end

      pfba_pkg::ST_CHECK: begin
        if (rd_data_q != pfba_pkg::FULL_WORD) begin
          if (out_free) begin
            wr_en     = 1'b1;
            wr_data   = rd_data_q | (DW'(1) << free_bit);
            res_load  = 1'b1;
            res_found = 1'b1;
            res_addr  = {cnt_q, free_bit, pfba_pkg::FRAME_SHIFT'(0)};
            res_word  = wr_data;
            state_d   = pfba_pkg::ST_IDLE;
          end
        end else if (cnt_last) begin
          // ran off the top of the map: nothing free
          if (out_free) begin
            res_load = 1'b1;
            state_d  = pfba_pkg::ST_IDLE;
          end
        end else begin
          rd_en   = 1'b1;
          rd_addr = cnt_q + AW'(1);
          cnt_d   = cnt_q + AW'(1);
        end
      end

      default: begin
        state_d = pfba_pkg::ST_IDLE;
      end
    endcase
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_addr_d  = out_addr_q;
    out_found_d = out_found_q;
    out_word_d  = out_word_q;
    if (res_load) begin
      out_valid_d = 1'b1;
      out_addr_d  = res_addr;
      out_found_d = res_found;
      out_word_d  = res_word;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pfba_pkg::ST_CLEAR;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nfr_q       <= nfr_d;
    is_free_q   <= is_free_d;
    bit_q       <= bit_d;
    out_addr_q  <= out_addr_d;
    out_found_q <= out_found_d;
    out_word_q  <= out_word_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_word_q, out_addr_q};
  assign m_axis_tuser  = out_found_q;

endmodule

// ===== verif/page_frame_bitmap_allocator_tb.sv =====
// ----------------------------------------------------------------------------
// page_frame_bitmap_allocator_tb
// Self-checking bench for the first-fit page frame bitmap allocator.
// ----------------------------------------------------------------------------
// Requests (init, mark, free, allocate) are queued by the stimulus process
// and streamed into the block by a falling-edge driver. Every accepted
// request is run through a local model of the used-frame map, and the
// predicted result is held until the block returns its transaction, where
// all three fields are compared. Both stream sides idle at random; one
// long receiver hold-off backs the block up into its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module page_frame_bitmap_allocator_tb;

  // Cycles without any transaction before the run is declared hung.
  localparam int unsigned STALL_LIMIT = 200000;
  // Length of the single long receiver hold-off
  localparam int          HOLD_CYCLES = 400;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] req_addr;
  } frame_req_t;

  typedef struct packed {
    logic [31:0] alloc_addr;
    logic        found;
    logic [31:0] word_after;
  } frame_result_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [31:0] cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;   // [31:0] frame byte address
  logic [1:0]  s_axis_tuser  = '0;   // [1:0] opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;         // [31:0] allocated_address, [63:32] word_after
  logic        m_axis_tuser;         // [0] found

  // Model state: used-frame map and the reserved end address copy
  logic [31:0]   frame_map_model [pfba_pkg::MAP_WORDS];
  logic [31:0]   rsv_end_model = '0;

  frame_req_t    pending_reqs [$];      // waiting for the driver
  frame_result_t expected_results [$];  // predicted, not yet returned

  int unsigned req_sent    = 0;  // requests queued so far
  int unsigned req_taken   = 0;  // requests accepted by the block
  int unsigned fail_cnt    = 0;
  int unsigned stall_cnt   = 0;
  int unsigned inits_left  = 6;  // budget for random inits, each is slow
  logic        in_fire     = 1'b0;
  bit          no_idle     = 1'b0;
  bit          hold_go     = 1'b0;
  bit          hold_done   = 1'b0;
  int          hold_left   = 0;

  page_frame_bitmap_allocator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Map model: applies one request and returns the block's expected answer
  // --------------------------------------------------------------------------
  function automatic frame_result_t predict_frame_op(input frame_req_t req);
    frame_result_t res;
    logic [32:0]   n_rsv;
    logic [19:0]   frame;
    logic [31:0]   v;
    int unsigned   w;
    int unsigned   b;
    bit            hit;
    res = '0;
    case (req.opcode)
      pfba_pkg::OP_INIT: begin
        // frames partly below the reserved end count as reserved (round up)
        n_rsv = ({1'b0, rsv_end_model} + 33'd4095) >> pfba_pkg::FRAME_SHIFT;
        for (w = 0; w < pfba_pkg::MAP_WORDS; w++) begin
          if (n_rsv >= 33'(w * pfba_pkg::WORD_BITS + pfba_pkg::WORD_BITS)) begin
            frame_map_model[w] = pfba_pkg::FULL_WORD;
          end else if (n_rsv > 33'(w * pfba_pkg::WORD_BITS)) begin
            frame_map_model[w] =
              (32'd1 << (n_rsv - 33'(w * pfba_pkg::WORD_BITS))) - 32'd1;
          end else begin
            frame_map_model[w] = '0;
          end
        end
      end
      pfba_pkg::OP_MARK, pfba_pkg::OP_FREE: begin
        // a 32-bit address always lands inside the map
        frame = req.req_addr[31:pfba_pkg::FRAME_SHIFT];
        frame_map_model[frame[19:5]][frame[4:0]] = (req.opcode == pfba_pkg::OP_MARK);
        res.word_after = frame_map_model[frame[19:5]];
      end
      pfba_pkg::OP_ALLOC: begin
        hit = 1'b0;
        // scan starts at reserved end / 4096 / 32
        for (w = rsv_end_model[31:17]; w < pfba_pkg::MAP_WORDS && !hit; w++) begin
          v = frame_map_model[w];
          if (v != pfba_pkg::FULL_WORD) begin
            b = 0;
            while (v[b]) b++;
            frame_map_model[w][b] = 1'b1;
            res.alloc_addr = 32'((w * pfba_pkg::WORD_BITS + b) << pfba_pkg::FRAME_SHIFT);
            res.found      = 1'b1;
            res.word_after = frame_map_model[w];
            hit            = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Input driver: falling edge, fed from pending_reqs
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin : req_driver
    frame_req_t nxt;
    if (!s_axis_tvalid || in_fire) begin
      // no idling while the receiver is held off: keep pushing into the block
      if (rst_ni && pending_reqs.size() > 0 &&
          (no_idle || hold_left > 0 || $urandom_range(99) >= 29)) begin
        nxt = pending_reqs.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= nxt.req_addr;
        s_axis_tuser  <= nxt.opcode;
      end else begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= $urandom();
        s_axis_tuser  <= 2'($urandom());
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output ready: random stalls plus one long hold-off on request, started
  // once a result is waiting so the block backs up behind it
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_go && !hold_done && m_axis_tvalid) begin
      hold_done     <= 1'b1;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= no_idle || ($urandom_range(99) >= 29);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: rising edge. Result check first, then prediction of a new
  // request, so a same-edge pair never pops its own expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_monitor
    frame_result_t got;
    frame_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.alloc_addr = m_axis_tdata[31:0];
      got.found      = m_axis_tuser;
      got.word_after = m_axis_tdata[63:32];
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual addr %h found %b word %h",
                 $time, got.alloc_addr, got.found, got.word_after);
        fail_cnt++;
      end else begin
        want = expected_results.pop_front();
        if (got.alloc_addr !== want.alloc_addr) begin
          $display("%0t: allocated_address mismatch, expected %h actual %h",
                   $time, want.alloc_addr, got.alloc_addr);
          fail_cnt++;
        end
        if (got.found !== want.found) begin
          $display("%0t: found mismatch, expected %b actual %b",
                   $time, want.found, got.found);
          fail_cnt++;
        end
        if (got.word_after !== want.word_after) begin
          $display("%0t: word_after mismatch, expected %h actual %h",
                   $time, want.word_after, got.word_after);
          fail_cnt++;
        end
      end
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      expected_results.push_back(predict_frame_op({s_axis_tuser, s_axis_tdata}));
      req_taken++;
    end
    in_fire <= rst_ni && s_axis_tvalid && s_axis_tready;
  end

  // Watchdog: consecutive cycles with no transaction on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
    if (stall_cnt >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, stall_cnt);
      $display("Test completed with failures");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_req(input logic [1:0] op, input logic [31:0] addr);
    pending_reqs.push_back({op, addr});
    req_sent++;
  endtask

  // Block is idle once every queued request has come back
  task automatic wait_drained();
    while (!(req_taken == req_sent && expected_results.size() == 0)) begin
      @(negedge clk_i);
    end
  endtask

  task automatic write_rsv_end(input logic [31:0] v);
    @(negedge clk_i);
    cfg_we_i      <= 1'b1;
    cfg_wdata_i   <= v;
    rsv_end_model  = v;
    @(negedge clk_i);
    cfg_we_i      <= 1'b0;
  endtask

  // Mostly frames around the scan start so marks and frees meet allocations
  function automatic logic [31:0] pick_req_addr(input int unsigned focus);
    int unsigned sel;
    int unsigned lo;
    int unsigned fr;
    sel = $urandom_range(99);
    if (sel < 55) begin
      lo = (focus >= 32) ? focus - 32 : 0;
      fr = lo + $urandom_range(127);
      if (fr > 1048575) fr = 1048575 - $urandom_range(63);
      return {20'(fr), 12'($urandom())};
    end else if (sel < 80) begin
      return $urandom();
    end
    case ($urandom_range(3))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return {20'(focus), 12'hFFF};
      default: return 32'hFFFF_F000;
    endcase
  endfunction

  task automatic run_random_phase(input logic [31:0] rsv, input bit with_init,
                                  input int n_items);
    int unsigned focus;
    int unsigned sel;
    logic [1:0]  op;
    wait_drained();
    write_rsv_end(rsv);
    if (with_init) push_req(pfba_pkg::OP_INIT, $urandom());
    focus = int'(rsv[31:17]) * pfba_pkg::WORD_BITS;
    for (int k = 0; k < n_items; k++) begin
      sel = $urandom_range(99);
      if (sel == 0 && inits_left > 0) begin
        inits_left--;
        op = pfba_pkg::OP_INIT;
      end else if (sel < 28) begin
        op = pfba_pkg::OP_MARK;
      end else if (sel < 52) begin
        op = pfba_pkg::OP_FREE;
      end else begin
        op = pfba_pkg::OP_ALLOC;
      end
      push_req(op, pick_req_addr(focus));
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    foreach (frame_map_model[i]) frame_map_model[i] = '0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reserved end 0, map clear: frame zero is handed out with found set
    write_rsv_end(32'h0000_0000);
    push_req(pfba_pkg::OP_ALLOC, 32'hFFFF_FFFF);
    push_req(pfba_pkg::OP_ALLOC, 32'h0000_0000);
    push_req(pfba_pkg::OP_MARK,  32'h0000_0FFF);   // already used, word unchanged
    push_req(pfba_pkg::OP_FREE,  32'h0000_1ABC);
    push_req(pfba_pkg::OP_FREE,  32'h0000_1000);   // already free, word unchanged
    push_req(pfba_pkg::OP_MARK,  32'hFFFF_FFFF);   // top frame of the map
    push_req(pfba_pkg::OP_FREE,  32'hFFFF_F000);
    push_req(pfba_pkg::OP_MARK,  32'h0000_2000);
    push_req(pfba_pkg::OP_ALLOC, 32'h0000_0000);
    push_req(pfba_pkg::OP_ALLOC, 32'h0000_0000);

    // everything reserved: allocate fails until the top frame is freed
    wait_drained();
    write_rsv_end(32'hFFFF_FFFF);
    push_req(pfba_pkg::OP_INIT,  32'hFFFF_FFFF);
    push_req(pfba_pkg::OP_ALLOC, 32'h0000_0000);
    push_req(pfba_pkg::OP_FREE,  32'hFFFF_F123);
    push_req(pfba_pkg::OP_ALLOC, 32'h0000_0000);
    push_req(pfba_pkg::OP_ALLOC, 32'h0000_0000);

    // reserved end inside a frame: that frame counts as reserved
    wait_drained();
    write_rsv_end(32'h0001_2345);
    push_req(pfba_pkg::OP_INIT,  32'h0000_0000);
    push_req(pfba_pkg::OP_ALLOC, 32'h0000_0000);
    push_req(pfba_pkg::OP_FREE,  32'h0001_2000);
    push_req(pfba_pkg::OP_ALLOC, 32'h0000_0000);

    // word 0 completely reserved: scan skips a full word
    wait_drained();
    write_rsv_end(32'h0001_FFFF);
    push_req(pfba_pkg::OP_INIT,  32'h5A5A_A5A5);
    push_req(pfba_pkg::OP_ALLOC, 32'h0000_0000);

    // random part: one setting per phase
    wait_drained();
    no_idle = 1'b1;
    run_random_phase(32'h0000_0000, 1'b0, 140);
    wait_drained();
    no_idle = 1'b0;
    run_random_phase(32'($urandom_range(32'h003F_FFFF)), 1'b1, 140);
    hold_go = 1'b1;   // receiver holds off while this phase streams in
    run_random_phase(32'hFFFE_0000 | 32'($urandom_range(32'h0001_FFFF)), 1'b1, 140);
    run_random_phase($urandom(), 1'b1, 140);
    run_random_phase(32'hFFFF_FFFF, 1'b1, 70);
    run_random_phase(32'h0000_0000, 1'b1, 70);

    wait_drained();
    repeat (50) @(posedge clk_i);
    if (fail_cnt == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/pfba_pkg.sv
design/page_frame_bitmap_allocator.sv
verif/page_frame_bitmap_allocator_tb.sv
